// File: sv/sss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sss_pkg
// Shared constants and types of the stable selection sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package sss_pkg;

    localparam int MAX_RECORDS = 64;
    localparam int ADDR_W      = $clog2(MAX_RECORDS);
    localparam int CNT_W       = $clog2(MAX_RECORDS + 1);

    localparam int TAG_W  = 8;
    localparam int AGE_W  = 7;
    localparam int INIT_W = 8;
    localparam int KEY_W  = 8;
    localparam int REC_W  = TAG_W + AGE_W + INIT_W;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_SELECT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DESCENDING = 1'd1;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [AGE_W-1:0]  age;
        logic [INIT_W-1:0] initial_byte;
    } t_record;

    typedef struct packed {
        logic              descending;
        logic              have_prev;
        logic [KEY_W-1:0]  prev_key;
        logic [ADDR_W-1:0] prev_idx;
        logic              have_best;
        logic [KEY_W-1:0]  best_key;
        logic [KEY_W-1:0]  cand_key;
        logic [ADDR_W-1:0] cand_idx;
    } t_cmp_in;

    typedef struct packed {
        logic qualify;
        logic take;
    } t_cmp_out;

endpackage

`default_nettype wire

// File: sv/sss_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sss_if
// Valid/ready channels of the sorter: record input, sorted output, config.
// ----------------------------------------------------------------------------
`default_nettype none

interface sss_in_if;
    logic                        valid;
    logic                        ready;
    logic [sss_pkg::TAG_W-1:0]   record_tag;
    logic [sss_pkg::AGE_W-1:0]   age_value;
    logic [sss_pkg::INIT_W-1:0]  name_initial;
    logic                        last_record;

    modport source (output valid, record_tag, age_value, name_initial, last_record,
                    input ready);
    modport sink (input valid, record_tag, age_value, name_initial, last_record,
                  output ready);
endinterface

interface sss_out_if;
    logic                        valid;
    logic                        ready;
    logic [sss_pkg::TAG_W-1:0]   sorted_tag;
    logic [sss_pkg::AGE_W-1:0]   sorted_age;
    logic [sss_pkg::INIT_W-1:0]  sorted_initial;
    logic                        end_of_run;

    modport source (output valid, sorted_tag, sorted_age, sorted_initial, end_of_run,
                    input ready);
    modport sink (input valid, sorted_tag, sorted_age, sorted_initial, end_of_run,
                  output ready);
endinterface

interface sss_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [sss_pkg::CFG_IDX_W-1:0]   index;
    logic [sss_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: sv/sss_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sss_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

// File: sv/sss_cmp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sss_cmp
// Shared ordering unit: decides whether a candidate follows the record last
// emitted and whether it beats the best record found so far in this pass.
// ----------------------------------------------------------------------------
`default_nettype none

module sss_cmp (
    input  wire sss_pkg::t_cmp_in  i_cmp,
    output sss_pkg::t_cmp_out      o_cmp
);

    logic prev_before_key;
    logic prev_equal_key;
    logic cand_before_best;

    // The order is by key in the chosen direction, then by load position.
    always_comb begin
        prev_before_key  = i_cmp.descending ? (i_cmp.prev_key > i_cmp.cand_key)
                                            : (i_cmp.prev_key < i_cmp.cand_key);
        prev_equal_key   = (i_cmp.prev_key == i_cmp.cand_key);
        cand_before_best = i_cmp.descending ? (i_cmp.cand_key > i_cmp.best_key)
                                            : (i_cmp.cand_key < i_cmp.best_key);
        o_cmp.qualify = !i_cmp.have_prev || prev_before_key ||
                        (prev_equal_key && (i_cmp.prev_idx < i_cmp.cand_idx));
        o_cmp.take    = o_cmp.qualify && (!i_cmp.have_best || cand_before_best);
    end

endmodule

`default_nettype wire

// File: sv/stable_selection_sorter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_selection_sorter
// Loads a set of records into a RAM and emits them in stable sorted order.
// ----------------------------------------------------------------------------
//  Channel   Direction  Beat contents
//  i_in      in         record_tag, age_value, name_initial, last_record
//  o_out     out        sorted_tag, sorted_age, sorted_initial, end_of_run
//  i_cfg     in         index (0 key_select, 1 descending), data
//
//  After the last load beat, each result takes a scan of all n stored records
//  through the single RAM read port, one compare per cycle.
//  Reset is synchronous and clears the record count and both config bits.
//  A stalled output beat holds the sorter; no load is taken until the run ends.
// ----------------------------------------------------------------------------
`default_nettype none

module stable_selection_sorter (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sss_in_if.sink     i_in,
    sss_out_if.source  o_out,
    sss_cfg_if.sink    i_cfg
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]                    r_state;
    logic [sss_pkg::CNT_W-1:0]     r_count;
    logic [sss_pkg::CNT_W-1:0]     r_n;
    logic [sss_pkg::CNT_W-1:0]     r_emitted;
    logic [sss_pkg::CNT_W-1:0]     r_scan;
    logic                          r_key_sel;
    logic                          r_desc;
    logic                          r_run_key_sel;
    logic                          r_run_desc;
    logic                          r_cmp_valid;
    logic [sss_pkg::ADDR_W-1:0]    r_cmp_idx;
    logic                          r_have_prev;
    logic [sss_pkg::KEY_W-1:0]     r_prev_key;
    logic [sss_pkg::ADDR_W-1:0]    r_prev_idx;
    logic                          r_have_best;
    logic [sss_pkg::KEY_W-1:0]     r_best_key;
    logic [sss_pkg::ADDR_W-1:0]    r_best_idx;
    sss_pkg::t_record              r_best_rec;
    logic                          r_out_valid;
    sss_pkg::t_record              r_out_rec;
    logic                          r_out_eor;

    logic                          in_beat;
    logic                          out_beat;
    logic                          has_room;
    logic [sss_pkg::CNT_W-1:0]     n_count;
    sss_pkg::t_record              wr_rec;
    sss_pkg::t_record              rd_rec;
    logic [sss_pkg::KEY_W-1:0]     cand_key;
    sss_pkg::t_cmp_in              cmp_in;
    sss_pkg::t_cmp_out             cmp_out;
    logic                          pass_done;
    logic [sss_pkg::KEY_W-1:0]     final_key;
    logic [sss_pkg::ADDR_W-1:0]    final_idx;
    sss_pkg::t_record              final_rec;
    logic [sss_pkg::CNT_W-1:0]     emitted_next;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_beat     = i_in.valid && i_in.ready;
    assign out_beat    = o_out.valid && o_out.ready;
    assign has_room    = (r_count < sss_pkg::CNT_W'(sss_pkg::MAX_RECORDS));
    assign n_count     = has_room ? (r_count + sss_pkg::CNT_W'(1)) : r_count;

    assign wr_rec.tag          = i_in.record_tag;
    assign wr_rec.age          = i_in.age_value;
    assign wr_rec.initial_byte = i_in.name_initial;

    sss_ram #(
        .WIDTH (sss_pkg::REC_W),
        .DEPTH (sss_pkg::MAX_RECORDS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (in_beat && has_room),
        .i_wr_addr (r_count[sss_pkg::ADDR_W-1:0]),
        .i_wr_data (wr_rec),
        .i_rd_addr (r_scan[sss_pkg::ADDR_W-1:0]),
        .o_rd_data (rd_rec)
    );

    assign cand_key = r_run_key_sel ? rd_rec.initial_byte
                                    : sss_pkg::KEY_W'(rd_rec.age);

    always_comb begin
        cmp_in.descending = r_run_desc;
        cmp_in.have_prev  = r_have_prev;
        cmp_in.prev_key   = r_prev_key;
        cmp_in.prev_idx   = r_prev_idx;
        cmp_in.have_best  = r_have_best;
        cmp_in.best_key   = r_best_key;
        cmp_in.cand_key   = cand_key;
        cmp_in.cand_idx   = r_cmp_idx;
    end

    sss_cmp u_cmp (
        .i_cmp (cmp_in),
        .o_cmp (cmp_out)
    );

    assign pass_done    = r_cmp_valid &&
                          (r_cmp_idx == sss_pkg::ADDR_W'(r_n - sss_pkg::CNT_W'(1)));
    assign final_key    = cmp_out.take ? cand_key : r_best_key;
    assign final_idx    = cmp_out.take ? r_cmp_idx : r_best_idx;
    assign final_rec    = cmp_out.take ? rd_rec : r_best_rec;
    assign emitted_next = r_emitted + sss_pkg::CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_sel <= 1'b0;
            r_desc    <= 1'b0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                sss_pkg::CFG_KEY_SELECT: r_key_sel <= i_cfg.data[0];
                sss_pkg::CFG_DESCENDING: r_desc    <= i_cfg.data[0];
                default:                 r_desc    <= r_desc;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_n         <= '0;
            r_emitted   <= '0;
            r_scan      <= '0;
            r_cmp_valid <= 1'b0;
            r_have_prev <= 1'b0;
            r_have_best <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    r_cmp_valid <= 1'b0;
                    if (in_beat) begin
                        r_count <= n_count;
                        if (i_in.last_record) begin
                            r_state       <= ST_SCAN;
                            r_n           <= n_count;
                            r_emitted     <= '0;
                            r_scan        <= '0;
                            r_have_prev   <= 1'b0;
                            r_have_best   <= 1'b0;
                            r_run_key_sel <= r_key_sel;
                            r_run_desc    <= r_desc;
                        end
                    end
                end
                ST_SCAN: begin
                    if (r_scan < r_n) begin
                        r_scan      <= r_scan + sss_pkg::CNT_W'(1);
                        r_cmp_valid <= 1'b1;
                        r_cmp_idx   <= r_scan[sss_pkg::ADDR_W-1:0];
                    end else begin
                        r_cmp_valid <= 1'b0;
                    end
                    if (r_cmp_valid && cmp_out.take) begin
                        r_have_best <= 1'b1;
                        r_best_key  <= cand_key;
                        r_best_idx  <= r_cmp_idx;
                        r_best_rec  <= rd_rec;
                    end
                    if (pass_done) begin
                        r_state     <= ST_EMIT;
                        r_out_valid <= 1'b1;
                        r_out_rec   <= final_rec;
                        r_out_eor   <= (emitted_next == r_n);
                        r_have_prev <= 1'b1;
                        r_prev_key  <= final_key;
                        r_prev_idx  <= final_idx;
                    end
                end
                ST_EMIT: begin
                    r_cmp_valid <= 1'b0;
                    if (out_beat) begin
                        r_out_valid <= 1'b0;
                        r_emitted   <= emitted_next;
                        r_have_best <= 1'b0;
                        r_scan      <= '0;
                        if (emitted_next == r_n) begin
                            r_state <= ST_IDLE;
                            r_count <= '0;
                        end else begin
                            r_state <= ST_SCAN;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.sorted_tag     = r_out_rec.tag;
    assign o_out.sorted_age     = r_out_rec.age;
    assign o_out.sorted_initial = r_out_rec.initial_byte;
    assign o_out.end_of_run     = r_out_eor;

    // The output register holds a record only while the sorter waits to hand it off.
    a_out_only_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (r_state == ST_EMIT))
        else $error("output beat offered outside the emit state");

    // Loading and emitting never overlap.
    a_no_load_during_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid))
        else $error("input ready while a sorted record is pending");

    // The final beat of a run returns the sorter to loading with an empty set.
    a_run_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_beat && o_out.end_of_run) |=> (i_in.ready && (r_count == '0)))
        else $error("sorter did not return to an empty load state after a run");

    // A pass never starts once every stored record has been emitted.
    a_emit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_emitted < r_n))
        else $error("scan pass started with no record left to emit");

endmodule

`default_nettype wire
